@@ hdl/iqr_pkg.sv @@
// Shared types and constants for the filtered median consensus block.
`timescale 1ns / 1ps
package iqr_pkg;
  localparam int PRICE_W = 63;
  localparam int ID_W    = 32;
  localparam int CNT_W   = 6;
  localparam int STAT_W  = 3;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [ID_W-1:0]    id_t;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STAT_W-1:0] ST_FEW       = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  localparam logic [1:0] CFG_MIN_PRICE   = 2'd0;
  localparam logic [1:0] CFG_MAX_PRICE   = 2'd1;
  localparam logic [1:0] CFG_MIN_SOURCES = 2'd2;

  typedef enum logic [2:0] {
    S_LOAD, S_QUART, S_DIST, S_LOW, S_HIGH, S_MID, S_AVG, S_DONE
  } state_t;

  // Broadcast from the controller into every cell of the row.
  typedef struct packed {
    logic   insert;
    logic   store_id;
    logic   clear;
    price_t price;
    id_t    id;
  } cell_bcast_t;
endpackage

@@ hdl/iqr_filtered_median_consensus.sv @@
// Top level of the filtered median consensus block.
`timescale 1ns / 1ps
// Usage:
//   Items (in_source_id, in_price, in_last) enter on start while busy is
//   low, one per cycle while loading. Prices inside [min_price, max_price]
//   drop into a row of MAX_ITEMS sorting cells; every cell compares its
//   price with the new one and shifts right in the same cycle, so the row
//   stays sorted. Each cell also compares its stored id with the new id.
//   The item marked last raises busy; a selection pass then reads the row
//   in order: quartiles, trim distance, a low trim scan and a high trim
//   scan (each steps over one trimmed price at a time, at most MAX_ITEMS/2
//   trimmed in all), median pick, average and a closing state. out_valid
//   is registered in the closing state. The result appears on
//   out_consensus_price/out_status/out_used_count for exactly one cycle
//   with out_valid; the receiver cannot stall.
//   busy is already low in the strobe cycle, so the next set may start.
//   Configuration is written on cfg_valid/cfg_ready, cfg_index, cfg_data;
//   cfg_ready is always high; the user must write only while idle, which
//   the block does not enforce. Reset (rst_n low, synchronous) clears the
//   set and restores the register defaults; no clearing pass is needed.
module iqr_filtered_median_consensus #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           in_source_id,
  input  logic [63:0]           in_price,
  input  logic                  in_last,
  output logic                  out_valid,
  output logic [62:0]           out_consensus_price,
  output logic [2:0]            out_status,
  output logic [5:0]            out_used_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data
);
  import iqr_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int NW = $clog2(MAX_ITEMS + 1);

  // Configuration registers.
  price_t          min_price_r, max_price_r;
  logic [CNT_W-1:0] min_src_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_price_r <= '0;
      max_price_r <= '1;
      min_src_r   <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_PRICE:   min_price_r <= cfg_data[PRICE_W-1:0];
        CFG_MAX_PRICE:   max_price_r <= cfg_data[PRICE_W-1:0];
        CFG_MIN_SOURCES: min_src_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Set state.
  state_t           state_r, state_nxt;
  logic [NW-1:0]    item_cnt_r, range_cnt_r;
  logic             dup_r, ovf_r;
  logic [NW-1:0]    lo_r, hi_r;
  price_t           q1_r, q3_r;
  logic [63:0]      d_r;
  price_t           pa_r, pb_r;
  logic             even_r;
  logic [62:0]      res_price_r;
  logic [2:0]       res_stat_r;
  logic [5:0]       res_used_r;
  logic             out_valid_r;

  cell_bcast_t      bc;
  logic [MAX_ITEMS-1:0] full_v, gt_v, match_v, id_sel;
  price_t           prices [MAX_ITEMS];

  logic accept, in_range, room;
  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;
  assign room   = (item_cnt_r < NW'(MAX_ITEMS));
  assign in_range = (in_price[63] == 1'b0) &&
                    (in_price[62:0] >= min_price_r) && (in_price[62:0] <= max_price_r);

  always_comb begin
    bc.insert   = accept && room && in_range;
    bc.store_id = accept && room;
    bc.clear    = (state_r == S_DONE);
    bc.price    = in_price[62:0];
    bc.id       = in_source_id;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ITEMS; g++) begin : g_row
      assign id_sel[g] = (item_cnt_r[IW-1:0] == IW'(g));
      if (g == 0) begin : g_first
        iqr_cell u_cell (
          .clk, .rst_n, .bc, .id_sel(id_sel[g]),
          .left_full(1'b1), .left_gt(1'b0), .left_price('0),
          .full(full_v[g]), .gt(gt_v[g]), .price(prices[g]), .id_match(match_v[g])
        );
      end else begin : g_rest
        iqr_cell u_cell (
          .clk, .rst_n, .bc, .id_sel(id_sel[g]),
          .left_full(full_v[g-1]), .left_gt(gt_v[g-1]), .left_price(prices[g-1]),
          .full(full_v[g]), .gt(gt_v[g]), .price(prices[g]), .id_match(match_v[g])
        );
      end
    end
  endgenerate

  // Selection pass helpers.
  logic [NW-1:0]  n, q1_idx, q3_idx, len, mid;
  logic [NW+1:0]  n3;
  price_t         p_lo, p_hi_m1;
  logic [63:0]    iqr;
  logic [63:0]    sum;
  assign n      = range_cnt_r;
  assign n3     = {2'b00, n} + {1'b0, n, 1'b0};
  assign q1_idx = n >> 2;
  assign q3_idx = NW'(n3 >> 2);
  assign iqr    = {1'b0, q3_r} - {1'b0, q1_r};
  assign p_lo   = prices[lo_r[IW-1:0]];
  assign p_hi_m1 = prices[IW'(hi_r - NW'(1))];
  assign len    = hi_r - lo_r;
  assign mid    = lo_r + (len >> 1);
  assign sum    = {1'b0, pa_r} + {1'b0, pb_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (accept && in_last) state_nxt = S_QUART;
      S_QUART: state_nxt = S_DIST;
      S_DIST:  state_nxt = S_LOW;
      S_LOW: begin
        if (!(lo_r < n && p_lo < q1_r && ({1'b0, q1_r} - {1'b0, p_lo}) > d_r)) begin
          state_nxt = S_HIGH;
        end
      end
      S_HIGH: begin
        if (!(hi_r > lo_r && p_hi_m1 > q3_r && ({1'b0, p_hi_m1} - {1'b0, q3_r}) > d_r)) begin
          state_nxt = S_MID;
        end
      end
      S_MID:   state_nxt = S_AVG;
      S_AVG:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      item_cnt_r  <= '0;
      range_cnt_r <= '0;
      dup_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (!room) begin
              ovf_r <= 1'b1;
            end else begin
              item_cnt_r <= item_cnt_r + NW'(1);
              if (in_range) range_cnt_r <= range_cnt_r + NW'(1);
              if (|match_v) dup_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          item_cnt_r  <= '0;
          range_cnt_r <= '0;
          dup_r       <= 1'b0;
          ovf_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath of the selection pass; no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      S_QUART: begin
        q1_r <= prices[q1_idx[IW-1:0]];
        q3_r <= prices[q3_idx[IW-1:0]];
        lo_r <= '0;
        hi_r <= n;
      end
      S_DIST: begin
        // Trim distance 1.5 * IQR from the registered quartiles.
        d_r <= iqr + (iqr >> 1);
      end
      S_LOW: begin
        if (lo_r < n && p_lo < q1_r && ({1'b0, q1_r} - {1'b0, p_lo}) > d_r) begin
          lo_r <= lo_r + NW'(1);
        end
      end
      S_HIGH: begin
        if (hi_r > lo_r && p_hi_m1 > q3_r && ({1'b0, p_hi_m1} - {1'b0, q3_r}) > d_r) begin
          hi_r <= hi_r - NW'(1);
        end else if (hi_r == lo_r || n < NW'(4)) begin
          // Small set or everything trimmed: fall back to the whole set.
          lo_r <= '0;
          hi_r <= n;
        end
      end
      S_MID: begin
        even_r <= ~len[0];
        pa_r   <= prices[IW'(mid - NW'(1))];
        pb_r   <= prices[mid[IW-1:0]];
      end
      S_AVG: begin
        res_price_r <= '0;
        res_used_r  <= '0;
        if (ovf_r) begin
          res_stat_r <= ST_OVERFLOW;
        end else if (dup_r) begin
          res_stat_r <= ST_DUP;
        end else if (32'(item_cnt_r) < 32'(min_src_r)) begin
          res_stat_r <= ST_FEW;
        end else if (n == '0) begin
          res_stat_r <= ST_NONE;
        end else begin
          res_stat_r  <= ST_OK;
          res_price_r <= even_r ? sum[63:1] : pb_r;
          res_used_r  <= CNT_W'(len);
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_consensus_price = res_price_r;
  assign out_status          = res_stat_r;
  assign out_used_count      = res_used_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result while still busy");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid && out_status != ST_OK
                   |-> out_consensus_price == '0 && out_used_count == '0)
    else $error("failed set must report zero");
  assert property (@(posedge clk) disable iff (!rst_n) range_cnt_r <= item_cnt_r)
    else $error("range count above item count");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_DONE) |=> out_valid)
    else $error("missing result strobe");
endmodule

@@ hdl/iqr_cell.sv @@
// One cell of the sorting row: holds one id and one sorted price.
`timescale 1ns / 1ps
module iqr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  iqr_pkg::cell_bcast_t bc,
  input  logic               id_sel,       // this cell takes the id
  input  logic               left_full,
  input  logic               left_gt,      // left neighbor price > new price
  input  iqr_pkg::price_t    left_price,
  output logic               full,
  output logic               gt,
  output iqr_pkg::price_t    price,
  output logic               id_match
);
  import iqr_pkg::*;

  logic   full_r, full_nxt;
  price_t price_r, price_nxt;
  id_t    id_r;
  logic   id_ok_r;

  assign gt       = full_r && (price_r > bc.price);
  assign full     = full_r;
  assign price    = price_r;
  assign id_match = id_ok_r && (id_r == bc.id);

  always_comb begin
    full_nxt  = full_r;
    price_nxt = price_r;
    if (bc.clear) begin
      full_nxt = 1'b0;
    end else if (bc.insert) begin
      if (full_r && gt) begin
        // shift right; take left price if it is also greater, else new one
        price_nxt = left_gt ? left_price : bc.price;
      end else if (!full_r && left_full) begin
        full_nxt  = 1'b1;
        price_nxt = left_gt ? left_price : bc.price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b0;
      id_ok_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
      if (bc.clear) begin
        id_ok_r <= 1'b0;
      end else if (bc.store_id && id_sel) begin
        id_ok_r <= 1'b1;
      end
    end
    price_r <= price_nxt;
    if (bc.store_id && id_sel) begin
      id_r <= bc.id;
    end
  end
endmodule
